// ----- design/xcfd_pkg.sv -----
// Shared types and constants for the XOR-checked frame deframer.
`timescale 1ns / 1ps

package xcfd_pkg;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_CMD     = 3'd1,
      PH_LEN_LO  = 3'd2,
      PH_LEN_HI  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_CHECK   = 3'd5,
      PH_END     = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      EV_DATA     = 3'd0,
      EV_ACCEPT   = 3'd1,
      EV_BAD_SUM  = 3'd2,
      EV_BAD_END  = 3'd3,
      EV_OVERSIZE = 3'd4
   } event_kind_type;

   localparam int unsigned ADDR_W = 4;

   localparam logic [1:0] REG_START_BYTE  = 2'd0;
   localparam logic [1:0] REG_END_BYTE    = 2'd1;
   localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

   localparam logic [7:0]  START_BYTE_RST  = 8'hAA;
   localparam logic [7:0]  END_BYTE_RST    = 8'h55;
   localparam logic [15:0] MAX_PAYLOAD_RST = 16'd2048;

   typedef struct packed {
      logic [7:0]  start_byte;
      logic [7:0]  end_byte;
      logic [15:0] max_payload;
   } cfg_type;

endpackage

// ----- design/xcfd_csr.sv -----
// Configuration register file with APB-style access.
`timescale 1ns / 1ps

module xcfd_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [xcfd_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready,
   output xcfd_pkg::cfg_type            cfg
);

   logic [7:0]  start_byte_ff;
   logic [7:0]  end_byte_ff;
   logic [15:0] max_payload_ff;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff  <= xcfd_pkg::START_BYTE_RST;
         end_byte_ff    <= xcfd_pkg::END_BYTE_RST;
         max_payload_ff <= xcfd_pkg::MAX_PAYLOAD_RST;
      end else if (wr_en) begin
         unique case (reg_idx)
            xcfd_pkg::REG_START_BYTE:  start_byte_ff  <= csr_pwdata[7:0];
            xcfd_pkg::REG_END_BYTE:    end_byte_ff    <= csr_pwdata[7:0];
            xcfd_pkg::REG_MAX_PAYLOAD: max_payload_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         xcfd_pkg::REG_START_BYTE:  csr_prdata = {24'd0, start_byte_ff};
         xcfd_pkg::REG_END_BYTE:    csr_prdata = {24'd0, end_byte_ff};
         xcfd_pkg::REG_MAX_PAYLOAD: csr_prdata = {16'd0, max_payload_ff};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   assign cfg.start_byte  = start_byte_ff;
   assign cfg.end_byte    = end_byte_ff;
   assign cfg.max_payload = max_payload_ff;

endmodule

// ----- design/xcfd_parser.sv -----
// Frame parser: input register, per-byte state update and result register.
`timescale 1ns / 1ps

module xcfd_parser (
   input  logic              clock,
   input  logic              reset,
   input  xcfd_pkg::cfg_type cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_rx_byte,
   input  logic              req_restart,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_event_kind,
   output logic [7:0]        rsp_frame_cmd,
   output logic [15:0]       rsp_frame_length,
   output logic [7:0]        rsp_data_byte,
   output logic              rsp_frame_end
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_restart_ff;

   // frame state
   xcfd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] seen_ff, seen_in;
   logic [7:0]  xor_ff, xor_in;

   // result register
   logic                     out_valid_ff;
   xcfd_pkg::event_kind_type kind_ff;
   logic [7:0]               out_cmd_ff;
   logic [15:0]              out_len_ff;
   logic [7:0]               data_ff;
   logic                     end_ff;

   logic                     advance;
   logic                     emit;
   xcfd_pkg::event_kind_type kind_in;
   logic [7:0]               data_in;
   logic [15:0]              len_full;
   logic [15:0]              seen_inc;

   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign len_full  = {in_byte_ff, len_ff[7:0]};
   assign seen_inc  = seen_ff + 16'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff    <= req_rx_byte;
         in_restart_ff <= req_restart;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      cmd_in   = cmd_ff;
      len_in   = len_ff;
      seen_in  = seen_ff;
      xor_in   = xor_ff;
      emit     = 1'b0;
      kind_in  = xcfd_pkg::EV_DATA;
      data_in  = 8'd0;
      if (in_restart_ff) begin
         phase_in = xcfd_pkg::PH_HUNT;
         cmd_in   = 8'd0;
         len_in   = 16'd0;
         seen_in  = 16'd0;
         xor_in   = 8'd0;
      end else begin
         unique case (phase_ff)
            xcfd_pkg::PH_CMD: begin
               cmd_in   = in_byte_ff;
               xor_in   = in_byte_ff;
               phase_in = xcfd_pkg::PH_LEN_LO;
            end
            xcfd_pkg::PH_LEN_LO: begin
               len_in   = {8'd0, in_byte_ff};
               xor_in   = xor_ff ^ in_byte_ff;
               phase_in = xcfd_pkg::PH_LEN_HI;
            end
            xcfd_pkg::PH_LEN_HI: begin
               len_in  = len_full;
               xor_in  = xor_ff ^ in_byte_ff;
               seen_in = 16'd0;
               if (len_full > cfg.max_payload) begin
                  phase_in = xcfd_pkg::PH_HUNT;
                  emit     = 1'b1;
                  kind_in  = xcfd_pkg::EV_OVERSIZE;
               end else if (len_full == 16'd0) begin
                  phase_in = xcfd_pkg::PH_CHECK;
               end else begin
                  phase_in = xcfd_pkg::PH_PAYLOAD;
               end
            end
            xcfd_pkg::PH_PAYLOAD: begin
               xor_in  = xor_ff ^ in_byte_ff;
               seen_in = seen_inc;
               if (seen_inc >= len_ff) begin
                  phase_in = xcfd_pkg::PH_CHECK;
               end
               emit    = 1'b1;
               kind_in = xcfd_pkg::EV_DATA;
               data_in = in_byte_ff;
            end
            xcfd_pkg::PH_CHECK: begin
               if (in_byte_ff != xor_ff) begin
                  phase_in = xcfd_pkg::PH_HUNT;
                  emit     = 1'b1;
                  kind_in  = xcfd_pkg::EV_BAD_SUM;
               end else begin
                  phase_in = xcfd_pkg::PH_END;
               end
            end
            xcfd_pkg::PH_END: begin
               phase_in = xcfd_pkg::PH_HUNT;
               emit     = 1'b1;
               kind_in  = (in_byte_ff == cfg.end_byte) ? xcfd_pkg::EV_ACCEPT
                                                       : xcfd_pkg::EV_BAD_END;
            end
            default: begin
               // hunting, and the unused phase code
               phase_in = xcfd_pkg::PH_HUNT;
               if (in_byte_ff == cfg.start_byte) begin
                  xor_in   = 8'd0;
                  seen_in  = 16'd0;
                  phase_in = xcfd_pkg::PH_CMD;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= xcfd_pkg::PH_HUNT;
         cmd_ff   <= 8'd0;
         len_ff   <= 16'd0;
         seen_ff  <= 16'd0;
         xor_ff   <= 8'd0;
      end else if (advance) begin
         phase_ff <= phase_in;
         cmd_ff   <= cmd_in;
         len_ff   <= len_in;
         seen_ff  <= seen_in;
         xor_ff   <= xor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= emit;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && emit) begin
         kind_ff    <= kind_in;
         out_cmd_ff <= cmd_in;
         out_len_ff <= len_in;
         data_ff    <= data_in;
         end_ff     <= (kind_in != xcfd_pkg::EV_DATA);
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_event_kind   = kind_ff;
   assign rsp_frame_cmd    = out_cmd_ff;
   assign rsp_frame_length = out_len_ff;
   assign rsp_data_byte    = data_ff;
   assign rsp_frame_end    = end_ff;

endmodule

// ----- design/xor_checked_frame_deframer.sv -----
// Top level of the XOR-checked frame deframer.
// A byte is registered in the input register on acceptance; its result is registered in the result register.
// Throughput: one byte per cycle; the result register lets the next byte enter while a
// result waits, and back-pressure on rsp stalls the single input register.
// Reset: synchronous, active high; parser returns to hunting with held values zero,
// registers return to start 0xAA, end 0x55, max payload 2048.
`timescale 1ns / 1ps

module xor_checked_frame_deframer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [7:0]                   req_rx_byte,
   input  logic                         req_restart,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [2:0]                   rsp_event_kind,
   output logic [7:0]                   rsp_frame_cmd,
   output logic [15:0]                  rsp_frame_length,
   output logic [7:0]                   rsp_data_byte,
   output logic                         rsp_frame_end,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [xcfd_pkg::ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   xcfd_pkg::cfg_type cfg;

   xcfd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   xcfd_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rx_byte      (req_rx_byte),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_frame_cmd    (rsp_frame_cmd),
      .rsp_frame_length (rsp_frame_length),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_frame_end    (rsp_frame_end)
   );

endmodule

// ----- test/frame_verdict_checker.sv -----
// Checker for the frame deframer: watches every port but csr_prdata, predicts each result and compares.
`timescale 1ns / 1ps

module frame_verdict_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [7:0]                    req_rx_byte,
   input  logic                          req_restart,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [2:0]                    rsp_event_kind,
   input  logic [7:0]                    rsp_frame_cmd,
   input  logic [15:0]                   rsp_frame_length,
   input  logic [7:0]                    rsp_data_byte,
   input  logic                          rsp_frame_end,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [xcfd_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   input  logic                          csr_pready,
   output int                            fail_count,
   output int                            pending
);

   typedef struct {
      xcfd_pkg::event_kind_type kind;
      logic [7:0]               cmd;
      logic [15:0]              length;
      logic [7:0]               data;
      logic                     frame_end;
   } deframe_event_type;

   deframe_event_type expected_events[$];

   xcfd_pkg::cfg_type   active_cfg;
   xcfd_pkg::phase_type parse_phase;
   logic [7:0]  cur_cmd;
   logic [15:0] cur_length;
   logic [15:0] payload_count;
   logic [7:0]  sum_acc;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   task automatic clear_frame();
      parse_phase   = xcfd_pkg::PH_HUNT;
      cur_cmd       = '0;
      cur_length    = '0;
      payload_count = '0;
      sum_acc       = '0;
   endtask

   task automatic push_event(input xcfd_pkg::event_kind_type kind, input logic [7:0] data,
                             input logic fend);
      deframe_event_type ev;
      ev.kind      = kind;
      ev.cmd       = cur_cmd;
      ev.length    = cur_length;
      ev.data      = data;
      ev.frame_end = fend;
      expected_events.push_back(ev);
   endtask

   task automatic advance_parser(input logic [7:0] b, input logic restart);
      if (restart) begin
         clear_frame();
      end else begin
         case (parse_phase)
            xcfd_pkg::PH_CMD: begin
               cur_cmd     = b;
               sum_acc     = b;
               parse_phase = xcfd_pkg::PH_LEN_LO;
            end
            xcfd_pkg::PH_LEN_LO: begin
               cur_length  = {8'h00, b};
               sum_acc     = sum_acc ^ b;
               parse_phase = xcfd_pkg::PH_LEN_HI;
            end
            xcfd_pkg::PH_LEN_HI: begin
               cur_length    = {b, cur_length[7:0]};
               sum_acc       = sum_acc ^ b;
               payload_count = '0;
               if (cur_length > active_cfg.max_payload) begin
                  parse_phase = xcfd_pkg::PH_HUNT;
                  push_event(xcfd_pkg::EV_OVERSIZE, 8'h00, 1'b1);
               end else begin
                  parse_phase = (cur_length == 16'd0) ? xcfd_pkg::PH_CHECK
                                                      : xcfd_pkg::PH_PAYLOAD;
               end
            end
            xcfd_pkg::PH_PAYLOAD: begin
               sum_acc       = sum_acc ^ b;
               payload_count = payload_count + 16'd1;
               if (payload_count >= cur_length) parse_phase = xcfd_pkg::PH_CHECK;
               push_event(xcfd_pkg::EV_DATA, b, 1'b0);
            end
            xcfd_pkg::PH_CHECK: begin
               if (b != sum_acc) begin
                  parse_phase = xcfd_pkg::PH_HUNT;
                  push_event(xcfd_pkg::EV_BAD_SUM, 8'h00, 1'b1);
               end else begin
                  parse_phase = xcfd_pkg::PH_END;
               end
            end
            xcfd_pkg::PH_END: begin
               parse_phase = xcfd_pkg::PH_HUNT;
               if (b == active_cfg.end_byte) push_event(xcfd_pkg::EV_ACCEPT, 8'h00, 1'b1);
               else push_event(xcfd_pkg::EV_BAD_END, 8'h00, 1'b1);
            end
            default: begin
               parse_phase = xcfd_pkg::PH_HUNT;
               if (b == active_cfg.start_byte) begin
                  sum_acc       = '0;
                  payload_count = '0;
                  parse_phase   = xcfd_pkg::PH_CMD;
               end
            end
         endcase
      end
   endtask

   task automatic report_field(input string field, input logic [15:0] exp_val,
                               input logic [15:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      deframe_event_type ev;
      if (reset) begin
         active_cfg.start_byte  = xcfd_pkg::START_BYTE_RST;
         active_cfg.end_byte    = xcfd_pkg::END_BYTE_RST;
         active_cfg.max_payload = xcfd_pkg::MAX_PAYLOAD_RST;
         clear_frame();
         expected_events.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[xcfd_pkg::ADDR_W-1:2])
               xcfd_pkg::REG_START_BYTE:  active_cfg.start_byte  = csr_pwdata[7:0];
               xcfd_pkg::REG_END_BYTE:    active_cfg.end_byte    = csr_pwdata[7:0];
               xcfd_pkg::REG_MAX_PAYLOAD: active_cfg.max_payload = csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_events.size() == 0) begin
               $display("%0t: unexpected transaction, expected none actual kind %0d",
                        $time, rsp_event_kind);
               fail_count++;
            end else begin
               ev = expected_events.pop_front();
               report_field("event_kind", 16'(ev.kind), 16'(rsp_event_kind));
               report_field("frame_cmd", 16'(ev.cmd), 16'(rsp_frame_cmd));
               report_field("frame_length", ev.length, rsp_frame_length);
               report_field("data_byte", 16'(ev.data), 16'(rsp_data_byte));
               report_field("frame_end", 16'(ev.frame_end), 16'(rsp_frame_end));
            end
         end
         if (req_valid && req_ready) advance_parser(req_rx_byte, req_restart);
      end
      pending = expected_events.size();
   end

endmodule

// ----- test/tb.sv -----
// Testbench top: drives frames and register settings into the deframer and gives the verdict.
`timescale 1ns / 1ps

module tb;

   localparam int IDLE_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 200;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_rx_byte;
   logic        req_restart;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_event_kind;
   logic [7:0]  rsp_frame_cmd;
   logic [15:0] rsp_frame_length;
   logic [7:0]  rsp_data_byte;
   logic        rsp_frame_end;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [xcfd_pkg::ADDR_W-1:0] csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending;
   int idle_cycles = 0;
   int byte_count = 0;
   bit sender_idle = 1'b1;
   bit receiver_idle = 1'b1;
   bit hold_req = 1'b0;
   logic [7:0] tx_bytes[$];
   xcfd_pkg::cfg_type cur_cfg;

   xor_checked_frame_deframer dut (.*);

   frame_verdict_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
         end else begin
            stall = receiver_idle ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
            while (!rsp_valid && !hold_req) @(posedge clock);
            @(negedge clock);
         end
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_byte(input logic [7:0] b, input logic restart);
      int gap;
      gap = sender_idle ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      req_restart <= restart;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (!restart) byte_count++;
      @(negedge clock);
   endtask

   task automatic flush_bytes();
      while (tx_bytes.size() != 0) send_byte(tx_bytes.pop_front(), 1'b0);
   endtask

   // leaves psel high so that writes can follow back to back
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // queue one frame: 0 good, 1 bad checksum, 2 bad end byte, 3 oversize header
   task automatic build_frame(input int flaw, input logic [7:0] cmd,
                              input logic [15:0] length);
      logic [7:0] sum;
      logic [7:0] b;
      sum = cmd ^ length[7:0] ^ length[15:8];
      tx_bytes.push_back(cur_cfg.start_byte);
      tx_bytes.push_back(cmd);
      tx_bytes.push_back(length[7:0]);
      tx_bytes.push_back(length[15:8]);
      if (flaw != 3) begin
         for (int i = 0; i < length; i++) begin
            b = 8'($urandom_range(0, 255));
            sum ^= b;
            tx_bytes.push_back(b);
         end
         tx_bytes.push_back(flaw == 1 ? sum ^ 8'($urandom_range(1, 255)) : sum);
         if (flaw != 1)
            tx_bytes.push_back(flaw == 2 ? cur_cfg.end_byte ^ 8'($urandom_range(1, 255))
                                         : cur_cfg.end_byte);
      end
   endtask

   function automatic logic [15:0] pick_length();
      int cap;
      cap = ($urandom_range(0, 19) == 0) ? 200 : 12;
      if (int'(cur_cfg.max_payload) < cap) cap = int'(cur_cfg.max_payload);
      return 16'($urandom_range(0, cap));
   endfunction

   task automatic random_frame();
      int sel;
      int cut;
      int n;
      logic [7:0] cmd;
      cmd = 8'($urandom_range(0, 255));
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
         build_frame(0, cmd, pick_length());
      end else if (sel < 70) begin
         build_frame(1, cmd, pick_length());
      end else if (sel < 78) begin
         build_frame(2, cmd, pick_length());
      end else if (sel < 86 && cur_cfg.max_payload != 16'hFFFF) begin
         case ($urandom_range(0, 2))
            0: build_frame(3, cmd, cur_cfg.max_payload + 16'd1);
            1: build_frame(3, cmd, 16'hFFFF);
            default: build_frame(3, cmd,
                        16'($urandom_range(int'(cur_cfg.max_payload) + 1, 65535)));
         endcase
      end else if (sel < 93) begin
         build_frame($urandom_range(0, 2), cmd, pick_length());
         cut = $urandom_range(1, tx_bytes.size() - 1);
         while (tx_bytes.size() > cut) void'(tx_bytes.pop_back());
         flush_bytes();
         send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         n = $urandom_range(1, 8);
         for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
         send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      flush_bytes();
   endtask

   task automatic apply_config(input logic [7:0] sb, input logic [7:0] eb,
                               input logic [15:0] mp);
      wait_drained();
      cur_cfg.start_byte  = sb;
      cur_cfg.end_byte    = eb;
      cur_cfg.max_payload = mp;
      csr_write(xcfd_pkg::REG_START_BYTE, {24'h0, sb});
      csr_write(xcfd_pkg::REG_END_BYTE, {24'h0, eb});
      csr_write(xcfd_pkg::REG_MAX_PAYLOAD, {16'h0, mp});
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   initial begin
      int goal;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = 8'h00;
      req_restart = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      cur_cfg.start_byte  = xcfd_pkg::START_BYTE_RST;
      cur_cfg.end_byte    = xcfd_pkg::END_BYTE_RST;
      cur_cfg.max_payload = xcfd_pkg::MAX_PAYLOAD_RST;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // good frame, cmd 0xFF, one zero payload byte
      tx_bytes = '{8'hAA, 8'hFF, 8'h01, 8'h00, 8'h00, 8'hFE, 8'h55};
      // bad checksum, then a start byte right after it opens an oversize header
      tx_bytes = {tx_bytes, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h01,
                  8'hAA, 8'h12, 8'hFF, 8'hFF};
      // bad end byte equal to the start byte, not taken as a start
      tx_bytes = {tx_bytes, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAA, 8'hAA, 8'h34};
      flush_bytes();
      send_byte(8'hAA, 1'b1);

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: apply_config(xcfd_pkg::START_BYTE_RST, xcfd_pkg::END_BYTE_RST,
                            xcfd_pkg::MAX_PAYLOAD_RST);
            1: apply_config(8'h00, 8'hFF, 16'h0000);
            2: apply_config(8'hFF, 8'h00, 16'hFFFF);
            3: apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                            16'($urandom_range(0, 20)));
            default: apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                  16'($urandom_range(0, 65535)));
         endcase
         if (ph == 0) begin
            // long receiver hold-off while the sender keeps pushing
            sender_idle = 1'b0;
            hold_req = 1'b1;
            build_frame(0, 8'h5A, 16'd40);
            flush_bytes();
            wait_drained();
         end
         goal = byte_count + PHASE_ITEMS;
         while (byte_count < goal) begin
            if ($urandom_range(0, 7) == 0) begin
               sender_idle   = $urandom_range(0, 2) != 0;
               receiver_idle = $urandom_range(0, 2) != 0;
            end
            random_frame();
         end
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
